>>> design/polar_gaussian_noise_generator_macros.svh
// assertion macros for the polar gaussian noise generator
`ifndef POLAR_GAUSSIAN_NOISE_GENERATOR_MACROS_SVH
`define POLAR_GAUSSIAN_NOISE_GENERATOR_MACROS_SVH

// same-cycle implication
`define PGN_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pgn assertion failed");

// next-cycle implication
`define PGN_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pgn assertion failed");

`endif

>>> design/pgn_pkg.sv
// shared constants and types of the polar gaussian noise generator
package pgn_pkg;

   localparam int LOG_STEPS  = 30;
   localparam int DIV_STEPS  = 38;
   localparam int SQRT_STEPS = 19;

   localparam logic [27:0] LN2_Q28 = 28'd186065279;
   localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

   localparam logic [1:0] CSR_MEAN_OFFSET = 2'd0;
   localparam logic [1:0] CSR_STD_DEV     = 2'd1;

   localparam logic [31:0] MEAN_RESET = 32'd0;
   localparam logic [30:0] STD_RESET  = 31'd65536;

   typedef struct packed {
      logic [29:0] w;
      logic [29:0] a_sq;
      logic [29:0] b_sq;
      logic        neg_a;
      logic        neg_b;
   } carry_type;

endpackage

>>> design/polar_gaussian_noise_generator.sv
// polar gaussian noise generator top level
// Usage:
//   req channel: one pair of uniform samples (signed Q1.15) per transfer,
//   taken when req_valid is high and req_stall is low.
//   rsp channel: signed Q16.16 samples, taken when rsp_valid is high and
//   rsp_stall is low. An accepted pair gives two transfers, the second with
//   rsp_last_of_pair set; a pair with w == 0 or w >= 1.0 gives none.
//   csr channel: csr_ready is always high; index 0 is the mean, index 1 the
//   standard deviation; other indexes are ignored. Write only when idle.
// Pipeline: the second sample of a pair leaves after the first. There are 97 stages
//   ahead of the response register: squares, sum and normalize, the 30-step log2
//   squaring chain, the log and product multiplies, the 38-step divider, the 19-step
//   root and the scaling stages.
// Throughput: one request per cycle while pairs are rejected; accepted pairs
//   are limited by the one-sample-per-cycle response port, the pipeline holding
//   while the second sample waits.
// Reset: clears all valid bits, the mean to 0 and the deviation to 1.0.
// Stall: a response stall freezes the whole pipeline and raises req_stall once
//   the final stage holds a pair; nothing is lost or repeated.
module polar_gaussian_noise_generator
   import pgn_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_uniform_a,
   input  logic signed [15:0] req_uniform_b,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_gauss_sample,
   output logic               rsp_last_of_pair,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_data
);

`include "polar_gaussian_noise_generator_macros.svh"

   function automatic logic [4:0] lead_zeros(input logic [29:0] v);
      logic [4:0] n;
      n = 5'd0;
      for (int i = 0; i < 30; i++) begin
         if (v[i]) begin
            n = 5'(29 - i);
         end
      end
      return n;
   endfunction

   function automatic logic [31:0] saturate(input logic [35:0] v);
      logic [31:0] r;
      if (!v[35] && (|v[34:31])) begin
         r = 32'h7FFF_FFFF;
      end else if (v[35] && !(&v[34:31])) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   logic               en;
   logic               can_load;

   logic signed [31:0] mean_offset_ff;
   logic [30:0]        std_dev_ff;

   logic               st1_valid_ff;
   logic [30:0]        st1_a_sq_ff;
   logic [30:0]        st1_b_sq_ff;
   logic               st1_neg_a_ff;
   logic               st1_neg_b_ff;
   logic signed [31:0] a_prod;
   logic signed [31:0] b_prod;

   logic [31:0]        st2_sum;
   logic               st2_ok;
   logic               st2_valid_ff;
   carry_type          st2_c_ff;

   logic               st3_valid_ff;
   carry_type          st3_c_ff;
   logic [4:0]         st3_s_ff;
   logic [30:0]        st3_x_ff;
   logic [4:0]         st3_s_in;
   logic [29:0]        st3_m;

   logic [LOG_STEPS-1:0] lg_valid_ff;
   logic [30:0]          lg_x_ff    [LOG_STEPS];
   logic [30:0]          lg_x_in    [LOG_STEPS];
   logic [29:0]          lg_frac_ff [LOG_STEPS];
   logic [29:0]          lg_frac_in [LOG_STEPS];
   logic [4:0]           lg_s_ff    [LOG_STEPS];
   carry_type            lg_c_ff    [LOG_STEPS];

   logic               nn_valid_ff;
   logic [34:0]        nn_ff;
   carry_type          nn_c_ff;

   logic               m1_valid_ff;
   logic [45:0]        m1_lo_ff;
   logic [44:0]        m1_hi_ff;
   carry_type          m1_c_ff;

   logic               m2_valid_ff;
   logic [33:0]        m2_l_ff;
   logic [62:0]        m2_sum;
   carry_type          m2_c_ff;

   logic               p1_valid_ff;
   logic [46:0]        p1_a_lo_ff;
   logic [46:0]        p1_a_hi_ff;
   logic [46:0]        p1_b_lo_ff;
   logic [46:0]        p1_b_hi_ff;
   carry_type          p1_c_ff;

   logic               p2_valid_ff;
   logic [63:0]        p2_a_ff;
   logic [63:0]        p2_b_ff;
   carry_type          p2_c_ff;

   logic               ln_a_valid;
   logic               ln_b_valid;
   logic               ln_a_neg;
   logic               ln_b_neg;
   logic [18:0]        ln_a_mag;
   logic [18:0]        ln_b_mag;

   logic               sc_valid_ff;
   logic [33:0]        sc_a_ff;
   logic [33:0]        sc_b_ff;
   logic               sc_neg_a_ff;
   logic               sc_neg_b_ff;
   logic [49:0]        sc_a_prod;
   logic [49:0]        sc_b_prod;

   logic               fin_valid_ff;
   logic [31:0]        fin_a_ff;
   logic [31:0]        fin_b_ff;
   logic [35:0]        mean_ext;
   logic [35:0]        fin_a_sum;
   logic [35:0]        fin_b_sum;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [31:0]        rsp_data_ff;
   logic [31:0]        rsp_data_in;
   logic               rsp_last_ff;
   logic               rsp_last_in;
   logic               pend_ff;
   logic               pend_in;
   logic [31:0]        pend_data_ff;
   logic [31:0]        pend_data_in;

   // flow control
   assign can_load  = !pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign en        = !fin_valid_ff || can_load;
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mean_offset_ff <= MEAN_RESET;
         std_dev_ff     <= STD_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MEAN_OFFSET: mean_offset_ff <= csr_data;
            CSR_STD_DEV:     std_dev_ff     <= csr_data[30:0];
            default: ;
         endcase
      end
   end

   // squares, sum and reject test, normalize
   assign a_prod   = req_uniform_a * req_uniform_a;
   assign b_prod   = req_uniform_b * req_uniform_b;
   assign st2_sum  = {1'b0, st1_a_sq_ff} + {1'b0, st1_b_sq_ff};
   assign st2_ok   = (st2_sum != 32'd0) && (st2_sum < ONE_Q30);
   assign st3_s_in = lead_zeros(st2_c_ff.w);
   assign st3_m    = st2_c_ff.w << st3_s_in;

   // log2 mantissa by repeated squaring, one fraction bit per stage
   always_comb begin
      logic [30:0] x;
      logic [29:0] fr;
      logic [61:0] sq;
      for (int k = 0; k < LOG_STEPS; k++) begin
         if (k == 0) begin
            x  = st3_x_ff;
            fr = '0;
         end else begin
            x  = lg_x_ff[k-1];
            fr = lg_frac_ff[k-1];
         end
         sq = 62'(x) * 62'(x);
         if (sq[61]) begin
            lg_x_in[k]    = sq[61:31];
            lg_frac_in[k] = {fr[28:0], 1'b1};
         end else begin
            lg_x_in[k]    = sq[60:30];
            lg_frac_in[k] = {fr[28:0], 1'b0};
         end
      end
   end

   assign m2_sum = 63'(m1_lo_ff) + {m1_hi_ff, 18'd0};

   // scaling and saturation
   assign sc_a_prod = 50'(std_dev_ff) * 50'(ln_a_mag);
   assign sc_b_prod = 50'(std_dev_ff) * 50'(ln_b_mag);
   assign mean_ext  = {{4{mean_offset_ff[31]}}, mean_offset_ff};
   assign fin_a_sum = sc_neg_a_ff ? mean_ext - {2'b00, sc_a_ff} : mean_ext + {2'b00, sc_a_ff};
   assign fin_b_sum = sc_neg_b_ff ? mean_ext - {2'b00, sc_b_ff} : mean_ext + {2'b00, sc_b_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_valid_ff <= 1'b0;
         st2_valid_ff <= 1'b0;
         st3_valid_ff <= 1'b0;
         lg_valid_ff  <= '0;
         nn_valid_ff  <= 1'b0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         sc_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         st1_valid_ff <= req_valid;
         st2_valid_ff <= st1_valid_ff && st2_ok;
         st3_valid_ff <= st2_valid_ff;
         lg_valid_ff  <= {lg_valid_ff[LOG_STEPS-2:0], st3_valid_ff};
         nn_valid_ff  <= lg_valid_ff[LOG_STEPS-1];
         m1_valid_ff  <= nn_valid_ff;
         m2_valid_ff  <= m1_valid_ff;
         p1_valid_ff  <= m2_valid_ff;
         p2_valid_ff  <= p1_valid_ff;
         sc_valid_ff  <= ln_a_valid && ln_b_valid;
         fin_valid_ff <= sc_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st1_a_sq_ff  <= a_prod[30:0];
         st1_b_sq_ff  <= b_prod[30:0];
         st1_neg_a_ff <= req_uniform_a[15];
         st1_neg_b_ff <= req_uniform_b[15];

         st2_c_ff.w     <= st2_sum[29:0];
         st2_c_ff.a_sq  <= st1_a_sq_ff[29:0];
         st2_c_ff.b_sq  <= st1_b_sq_ff[29:0];
         st2_c_ff.neg_a <= st1_neg_a_ff;
         st2_c_ff.neg_b <= st1_neg_b_ff;

         st3_c_ff <= st2_c_ff;
         st3_s_ff <= st3_s_in;
         st3_x_ff <= {st3_m, 1'b0};

         for (int k = 0; k < LOG_STEPS; k++) begin
            lg_x_ff[k]    <= lg_x_in[k];
            lg_frac_ff[k] <= lg_frac_in[k];
         end
         lg_s_ff[0] <= st3_s_ff;
         lg_c_ff[0] <= st3_c_ff;
         for (int k = 1; k < LOG_STEPS; k++) begin
            lg_s_ff[k] <= lg_s_ff[k-1];
            lg_c_ff[k] <= lg_c_ff[k-1];
         end

         nn_ff   <= {5'(lg_s_ff[LOG_STEPS-1] + 5'd1), 30'd0}
                  - {5'd0, lg_frac_ff[LOG_STEPS-1]};
         nn_c_ff <= lg_c_ff[LOG_STEPS-1];

         m1_lo_ff <= 46'(nn_ff[17:0]) * 46'(LN2_Q28);
         m1_hi_ff <= 45'(nn_ff[34:18]) * 45'(LN2_Q28);
         m1_c_ff  <= nn_c_ff;

         m2_l_ff <= m2_sum[62:29];
         m2_c_ff <= m1_c_ff;

         p1_a_lo_ff <= 47'(m2_c_ff.a_sq) * 47'(m2_l_ff[16:0]);
         p1_a_hi_ff <= 47'(m2_c_ff.a_sq) * 47'(m2_l_ff[33:17]);
         p1_b_lo_ff <= 47'(m2_c_ff.b_sq) * 47'(m2_l_ff[16:0]);
         p1_b_hi_ff <= 47'(m2_c_ff.b_sq) * 47'(m2_l_ff[33:17]);
         p1_c_ff    <= m2_c_ff;

         p2_a_ff <= {p1_a_hi_ff, 17'd0} + 64'(p1_a_lo_ff);
         p2_b_ff <= {p1_b_hi_ff, 17'd0} + 64'(p1_b_lo_ff);
         p2_c_ff <= p1_c_ff;

         sc_a_ff     <= sc_a_prod[49:16];
         sc_b_ff     <= sc_b_prod[49:16];
         sc_neg_a_ff <= ln_a_neg;
         sc_neg_b_ff <= ln_b_neg;

         fin_a_ff <= saturate(fin_a_sum);
         fin_b_ff <= saturate(fin_b_sum);
      end
   end

   pgn_lane u_lane_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p2_valid_ff),
      .in_prod   (p2_a_ff),
      .in_w      (p2_c_ff.w),
      .in_neg    (p2_c_ff.neg_a),
      .out_valid (ln_a_valid),
      .out_neg   (ln_a_neg),
      .out_mag   (ln_a_mag)
   );

   pgn_lane u_lane_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (p2_valid_ff),
      .in_prod   (p2_b_ff),
      .in_w      (p2_c_ff.w),
      .in_neg    (p2_c_ff.neg_b),
      .out_valid (ln_b_valid),
      .out_neg   (ln_b_neg),
      .out_mag   (ln_b_mag)
   );

   // response register with a hold slot for the second sample
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      pend_in      = pend_ff;
      pend_data_in = pend_data_ff;
      if (pend_ff) begin
         if (!rsp_stall) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = pend_data_ff;
            rsp_last_in  = 1'b1;
            pend_in      = 1'b0;
         end
      end else if (fin_valid_ff && can_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fin_a_ff;
         rsp_last_in  = 1'b0;
         pend_in      = 1'b1;
         pend_data_in = fin_b_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      pend_data_ff <= pend_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_gauss_sample = rsp_data_ff;
   assign rsp_last_of_pair = rsp_last_ff;

   `PGN_ASSERT_NOW(a_pend_behind_first, clock, reset, pend_ff, rsp_valid_ff && !rsp_last_ff)
   `PGN_ASSERT_NEXT(a_second_follows, clock, reset, rsp_valid && !rsp_stall && !rsp_last_of_pair, rsp_valid && rsp_last_of_pair)
   `PGN_ASSERT_NOW(a_empty_tail_flows, clock, reset, !fin_valid_ff, !req_stall)
   `PGN_ASSERT_NEXT(a_pair_loads, clock, reset, fin_valid_ff && !req_stall, rsp_valid && !rsp_last_of_pair && pend_ff)

endmodule

>>> design/pgn_lane.sv
// pipelined divider and square root for one deviate
module pgn_lane
   import pgn_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [63:0] in_prod,
   input  logic [29:0] in_w,
   input  logic        in_neg,
   output logic        out_valid,
   output logic        out_neg,
   output logic [18:0] out_mag
);

   logic [DIV_STEPS-1:0] dv_valid_ff;
   logic [DIV_STEPS-1:0] dv_neg_ff;
   logic [29:0]          dv_rem_ff [DIV_STEPS];
   logic [29:0]          dv_rem_in [DIV_STEPS];
   logic [37:0]          dv_low_ff [DIV_STEPS];
   logic [37:0]          dv_low_in [DIV_STEPS];
   logic [37:0]          dv_quo_ff [DIV_STEPS];
   logic [37:0]          dv_quo_in [DIV_STEPS];
   logic [29:0]          dv_w_ff   [DIV_STEPS];

   logic [SQRT_STEPS-1:0] sq_valid_ff;
   logic [SQRT_STEPS-1:0] sq_neg_ff;
   logic [19:0]           sq_rem_ff  [SQRT_STEPS];
   logic [19:0]           sq_rem_in  [SQRT_STEPS];
   logic [18:0]           sq_root_ff [SQRT_STEPS];
   logic [18:0]           sq_root_in [SQRT_STEPS];
   logic [37:0]           sq_x_ff    [SQRT_STEPS];
   logic [37:0]           sq_x_in    [SQRT_STEPS];

   // restoring division, one quotient bit per stage
   always_comb begin
      logic [29:0] rem;
      logic [37:0] low;
      logic [37:0] quo;
      logic [29:0] dw;
      logic [30:0] t;
      logic        ge;
      for (int k = 0; k < DIV_STEPS; k++) begin
         if (k == 0) begin
            rem = in_prod[63:34];
            low = {in_prod[33:0], 4'd0};
            quo = '0;
            dw  = in_w;
         end else begin
            rem = dv_rem_ff[k-1];
            low = dv_low_ff[k-1];
            quo = dv_quo_ff[k-1];
            dw  = dv_w_ff[k-1];
         end
         t  = {rem, low[37]};
         ge = (t >= {1'b0, dw});
         if (ge) begin
            dv_rem_in[k] = 30'(t - {1'b0, dw});
         end else begin
            dv_rem_in[k] = t[29:0];
         end
         dv_low_in[k] = {low[36:0], 1'b0};
         dv_quo_in[k] = {quo[36:0], ge};
      end
   end

   // digit-by-digit square root, one root bit per stage
   always_comb begin
      logic [19:0] rem;
      logic [18:0] root;
      logic [37:0] x;
      logic [21:0] t;
      logic [20:0] trial;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         if (k == 0) begin
            rem  = '0;
            root = '0;
            x    = dv_quo_ff[DIV_STEPS-1];
         end else begin
            rem  = sq_rem_ff[k-1];
            root = sq_root_ff[k-1];
            x    = sq_x_ff[k-1];
         end
         t     = {rem, x[37:36]};
         trial = {root, 2'b01};
         if (t >= {1'b0, trial}) begin
            sq_rem_in[k]  = 20'(t - {1'b0, trial});
            sq_root_in[k] = {root[17:0], 1'b1};
         end else begin
            sq_rem_in[k]  = t[19:0];
            sq_root_in[k] = {root[17:0], 1'b0};
         end
         sq_x_in[k] = {x[35:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff <= '0;
         sq_valid_ff <= '0;
      end else if (en) begin
         dv_valid_ff <= {dv_valid_ff[DIV_STEPS-2:0], in_valid};
         sq_valid_ff <= {sq_valid_ff[SQRT_STEPS-2:0], dv_valid_ff[DIV_STEPS-1]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dv_neg_ff <= {dv_neg_ff[DIV_STEPS-2:0], in_neg};
         sq_neg_ff <= {sq_neg_ff[SQRT_STEPS-2:0], dv_neg_ff[DIV_STEPS-1]};
         for (int k = 0; k < DIV_STEPS; k++) begin
            dv_rem_ff[k] <= dv_rem_in[k];
            dv_low_ff[k] <= dv_low_in[k];
            dv_quo_ff[k] <= dv_quo_in[k];
            dv_w_ff[k]   <= (k == 0) ? in_w : dv_w_ff[(k == 0) ? 0 : k-1];
         end
         for (int k = 0; k < SQRT_STEPS; k++) begin
            sq_rem_ff[k]  <= sq_rem_in[k];
            sq_root_ff[k] <= sq_root_in[k];
            sq_x_ff[k]    <= sq_x_in[k];
         end
      end
   end

   assign out_valid = sq_valid_ff[SQRT_STEPS-1];
   assign out_neg   = sq_neg_ff[SQRT_STEPS-1];
   assign out_mag   = sq_root_ff[SQRT_STEPS-1];

endmodule
